>>> rtl/bale_pkg.sv
// bale_pkg: shared types and constants for the bounded array list engine.
// Holds request/status codes, cell command and compare-hit structs.
// No dependencies.
`default_nettype none

package bale_pkg;

  // Default list depth and fixed field widths
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned POSITION_W   = 5;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned INDEX_W      = 4;
  localparam int unsigned FILL_W       = 5;
  // Wide enough for any index or count up to the largest supported depth (256)
  localparam int unsigned POS_W        = 9;

  // Stream payload widths (tdata padded to whole bytes)
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned IN_TUSER_W   = MODE_W;
  localparam int unsigned OUT_TDATA_W  = 16;
  localparam int unsigned OUT_TUSER_W  = STATUS_W;

  // Request kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOCATE = 2'd2,
    MODE_SORTED = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // What every cell does on this cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // Broadcast shift command from the controller to the cell row
  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   target;
  } cell_cmd_t;

  // Per-cell compare results against the request value
  typedef struct packed {
    logic eq;
    logic gt;
  } cell_hit_t;

endpackage

`default_nettype wire

>>> rtl/bale_cell.sv
// bale_cell: one list slot; holds an entry, compares it with the request
// value and shifts to/from its neighbors. Depends on bale_pkg.
`default_nettype none

module bale_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire                            clk,
  input  bale_pkg::cell_cmd_t            cmd,
  input  logic [bale_pkg::POS_W-1:0]     count,
  input  logic signed [bale_pkg::VALUE_W-1:0] value,
  input  logic signed [bale_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [bale_pkg::VALUE_W-1:0] right_entry,
  output logic signed [bale_pkg::VALUE_W-1:0] entry,
  output bale_pkg::cell_hit_t            hit
);
  import bale_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(CELL_IDX);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;
  logic                      occupied;

  assign entry    = entry_r;
  assign occupied = (MY_IDX < count);

  // Compare against the request value; empty slots never hit
  always_comb begin
    hit.eq = occupied && (entry_r == value);
    hit.gt = occupied && (entry_r > value);
  end

  // Shift or load
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX > cmd.target) begin
          entry_nxt = left_entry;
        end else if (MY_IDX == cmd.target) begin
          entry_nxt = value;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= cmd.target) begin
          entry_nxt = right_entry;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/bale_first_hit.sv
// bale_first_hit: priority encoder giving the lowest set bit of a hit row.
// Used for locate and sorted insert. Depends on bale_pkg.
`default_nettype none

module bale_first_hit #(
  parameter int unsigned N = bale_pkg::CAPACITY_DEF
) (
  input  logic [N-1:0]           hits,
  output logic                   found,
  output logic [$clog2(N)-1:0]   idx
);
  import bale_pkg::*;

  // Scan from the top so the lowest hit wins
  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hits[i]) begin
        idx = ($clog2(N))'(i);
      end
    end
  end

  assign found = |hits;

endmodule

`default_nettype wire

>>> rtl/bounded_array_list_engine_core.sv
// bounded_array_list_engine_core: top level of the bounded ordered list.
// Depends on bale_pkg, bale_cell, bale_first_hit.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: mode; tdata: value, position
//  out_    | out | out_tvalid/out_tready| tuser: status; tdata: index, fill
//
// Cycles: one transaction per clock while results are taken. A request is
// decided and the cell row shifted at the accepting edge; its result sits
// in the output register from the next cycle on. The figure is set by the
// compare row plus the first-hit encoder feeding the cell shift controls.
// Reset: clears the fill count and output valid; entries are not cleared.
// Stalls: a new request is taken while the held result is taken in the same
// cycle; an untaken result blocks the input.
`default_nettype none

module bounded_array_list_engine_core #(
  parameter int unsigned CAPACITY = bale_pkg::CAPACITY_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bale_pkg::IN_TDATA_W-1:0]    in_tdata,  // [31:0] value, [36:32] position
  input  logic [bale_pkg::IN_TUSER_W-1:0]    in_tuser,  // [1:0] mode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bale_pkg::OUT_TDATA_W-1:0]   out_tdata, // [3:0] index, [8:4] fill
  output logic [bale_pkg::OUT_TUSER_W-1:0]   out_tuser  // [1:0] status
);
  import bale_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

  // Control state
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [INDEX_W-1:0] index_r;
  logic [FILL_W-1:0]  fill_r;

  logic                      accept;
  mode_t                     mode;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          pos_p, cnt_p, idx_p;
  logic                      full;
  cell_cmd_t                 cmd;

  // Cell row wiring
  logic signed [VALUE_W-1:0] entry_q [CAPACITY];
  logic [CAPACITY-1:0]       eq_vec, gt_vec;
  logic                      eq_found, gt_found;
  logic [IDX_W-1:0]          eq_idx, gt_idx;

  // Unpack request
  assign mode   = mode_t'(in_tuser[MODE_W-1:0]);
  assign value  = $signed(in_tdata[VALUE_W-1:0]);
  assign pos_p  = POS_W'(in_tdata[VALUE_W +: POSITION_W]);
  assign cnt_p  = POS_W'(count_r);
  assign full   = (cnt_p == CAP_P);

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_e, right_e;
    cell_hit_t                 hit;
    if (g == 0) begin : g_first
      assign left_e = value;
    end else begin : g_mid
      assign left_e = entry_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_e = entry_q[g];
    end else begin : g_inner
      assign right_e = entry_q[g+1];
    end
    bale_cell #(.CELL_IDX(g)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (cnt_p),
      .value       (value),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (entry_q[g]),
      .hit         (hit)
    );
    assign eq_vec[g] = hit.eq;
    assign gt_vec[g] = hit.gt;
  end

  // First equal entry and first larger entry
  bale_first_hit #(.N(CAPACITY)) u_eq_enc (
    .hits  (eq_vec),
    .found (eq_found),
    .idx   (eq_idx)
  );

  bale_first_hit #(.N(CAPACITY)) u_gt_enc (
    .hits  (gt_vec),
    .found (gt_found),
    .idx   (gt_idx)
  );

  // Request decode
  always_comb begin
    status_nxt = ST_DONE;
    idx_p      = '0;
    count_nxt  = count_r;
    cmd.op     = CELL_HOLD;
    cmd.target = '0;
    unique case (mode)
      MODE_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_p > cnt_p) begin
          status_nxt = ST_BADPOS;
        end else begin
          idx_p      = pos_p;
          cmd.op     = CELL_INSERT;
          cmd.target = pos_p;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (pos_p >= cnt_p) begin
          status_nxt = ST_BADPOS;
        end else begin
          idx_p      = pos_p;
          cmd.op     = CELL_DELETE;
          cmd.target = pos_p;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      MODE_LOCATE: begin
        if (eq_found) begin
          idx_p = POS_W'(eq_idx);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      MODE_SORTED: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          idx_p      = gt_found ? POS_W'(gt_idx) : cnt_p;
          cmd.op     = CELL_INSERT;
          cmd.target = idx_p;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      default: status_nxt = ST_DONE;
    endcase
    if (!accept) begin
      cmd.op    = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  // Fill count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      index_r  <= idx_p[INDEX_W-1:0];
      fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {(OUT_TDATA_W - INDEX_W - FILL_W)'(0), fill_r, index_r};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    POS_W'(count_r) <= CAP_P)
    else $error("fill count exceeds capacity");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fill_r == FILL_W'(count_r)))
    else $error("reported fill differs from fill count");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status_nxt == ST_FULL || status_nxt == ST_BADPOS)) |=> $stable(count_r))
    else $error("rejected request changed the fill count");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_DONE) |-> (index_r == '0))
    else $error("nonzero index with failing status");

endmodule

`default_nettype wire

>>> test/tb_bounded_array_list_engine_core.sv
// tb_bounded_array_list_engine_core: self-checking bench for the bounded list engine.
// Depends on bale_pkg and bounded_array_list_engine_core; a tracker class keeps
// its own copy of the list and checks every result transaction against it.
module tb_bounded_array_list_engine_core;
  import bale_pkg::*;

  localparam int unsigned LIST_DEPTH  = CAPACITY_DEF;
  localparam int unsigned RANDOM_REQS = 750;
  localparam int unsigned QUIET_TAIL  = 100;
  localparam int unsigned STALL_HOLD  = 60;
  localparam int unsigned IDLE_LIMIT  = 2000;

  // One predicted result transaction
  typedef struct {
    status_t    status;
    logic [3:0] index;
    logic [4:0] fill;
  } list_result_t;

  // Tracks list contents and the results still owed by the engine
  class list_tracker;
    logic signed [31:0] vals [LIST_DEPTH];
    int unsigned        fill;
    list_result_t       pending_results[$];
    int unsigned        errors;
    int unsigned        results_seen;

    function new();
      fill         = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // open a slot and write the value there
    function void put_at(int unsigned slot, logic signed [31:0] value);
      for (int unsigned i = fill; i > slot; i--) vals[i] = vals[i-1];
      vals[slot] = value;
      fill++;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(mode_t mode, logic signed [31:0] value,
                               logic [4:0] position);
      list_result_t r;
      int unsigned  i;
      r.status = ST_DONE;
      r.index  = '0;
      case (mode)
        MODE_INSERT: begin
          if (fill >= LIST_DEPTH) r.status = ST_FULL;
          else if (position > fill) r.status = ST_BADPOS;
          else begin
            put_at(position, value);
            r.index = position[3:0];
          end
        end
        MODE_DELETE: begin
          if (position >= fill) r.status = ST_BADPOS;
          else begin
            for (i = position; i + 1 < fill; i++) vals[i] = vals[i+1];
            fill--;
            r.index = position[3:0];
          end
        end
        MODE_LOCATE: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < fill; i++) begin
            if (vals[i] == value) begin
              r.status = ST_DONE;
              r.index  = i[3:0];
              break;
            end
          end
        end
        default: begin
          // sorted insert: ahead of the first strictly larger entry
          if (fill >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            i = 0;
            while (i < fill && !(vals[i] > value)) i++;
            put_at(i, value);
            r.index = i[3:0];
          end
        end
      endcase
      r.fill = fill[4:0];
      pending_results.push_back(r);
    endfunction

    // Compare one accepted result transaction with the oldest prediction
    function void check_result(status_t status, logic [3:0] index, logic [4:0] fill_now);
      list_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d index %0d fill %0d",
               status, index, fill_now);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (index !== want.index) begin
        $error("index: expected %0d, got %0d", want.index, index);
        errors++;
      end
      if (fill_now !== want.fill) begin
        $error("fill: expected %0d, got %0d", want.fill, fill_now);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] value, [36:32] position
  logic [IN_TUSER_W-1:0]  in_tuser;   // [1:0] mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [3:0] index, [8:4] fill
  logic [OUT_TUSER_W-1:0] out_tuser;  // [1:0] status

  list_tracker tracker;
  bit          quiet;
  bit          stall_done;
  int unsigned idle_cycles;

  bounded_array_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Offer one request and hold it until the engine takes it
  task automatic send_request(mode_t mode, logic signed [31:0] value, logic [4:0] position);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {3'b000, position, value};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(mode, value, position);
  endtask

  // Drop valid for a burst of cycles
  task automatic idle_input(int unsigned cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Mix of small values (ties, hits), extremes and full-range noise
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $signed($urandom_range(0, 8)) - 4;
    if (r < 42) return 32'sh8000_0000;
    if (r < 49) return 32'sh7fff_ffff;
    return $urandom;
  endfunction

  // Result side: check every accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(status_t'(out_tuser), out_tdata[3:0], out_tdata[8:4]);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold, none in the tail
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && !stall_done && tracker.results_seen >= 100) begin
        stall_done = 1'b1;
        out_tready <= 1'b0;
        repeat (STALL_HOLD - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned        r;
    int unsigned        fill_now;
    bit                 grow;
    mode_t              mode;
    logic signed [31:0] value;
    logic [4:0]         position;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    quiet       = 1'b0;
    stall_done  = 1'b0;
    idle_cycles = 0;
    tracker     = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-list corners, extremes, ties, full list, both deletes ends
    send_request(MODE_LOCATE, 32'sd5, 5'd0);
    send_request(MODE_DELETE, 32'sd0, 5'd31);
    send_request(MODE_INSERT, 32'sd1, 5'd1);
    send_request(MODE_INSERT, 32'sh8000_0000, 5'd0);
    send_request(MODE_SORTED, 32'sh7fff_ffff, 5'd0);
    send_request(MODE_SORTED, 32'sd0, 5'd0);
    send_request(MODE_SORTED, 32'sd0, 5'd17);
    for (int k = 0; k < 12; k++)
      send_request(MODE_SORTED, 32'sd40 - (k % 6) * 9, 5'd0);
    send_request(MODE_INSERT, 32'sd3, 5'd0);
    send_request(MODE_SORTED, 32'sd3, 5'd0);
    send_request(MODE_LOCATE, 32'sd22, 5'd0);
    send_request(MODE_LOCATE, 32'sd99, 5'd0);
    send_request(MODE_DELETE, 32'sd0, 5'd15);
    send_request(MODE_DELETE, 32'sd0, 5'd0);

    // Random: drift the fill up and down so both ends are visited often
    grow = 1'b1;
    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      if (n >= RANDOM_REQS - QUIET_TAIL) quiet = 1'b1;
      fill_now = tracker.fill;
      if (fill_now >= LIST_DEPTH) grow = 1'b0;
      else if (fill_now == 0) grow = 1'b1;
      else if ($urandom_range(0, 49) == 0) grow = ~grow;

      r = $urandom_range(0, 99);
      if (grow) mode = (r < 35) ? MODE_SORTED : (r < 65) ? MODE_INSERT :
                       (r < 80) ? MODE_DELETE : MODE_LOCATE;
      else      mode = (r < 15) ? MODE_SORTED : (r < 30) ? MODE_INSERT :
                       (r < 75) ? MODE_DELETE : MODE_LOCATE;

      value = pick_value();
      if (mode == MODE_LOCATE && fill_now > 0 && $urandom_range(0, 9) < 6)
        value = tracker.vals[$urandom_range(0, fill_now - 1)];

      if ($urandom_range(0, 99) < 15) position = 5'($urandom_range(0, 31));
      else if (mode == MODE_DELETE && fill_now > 0)
        position = 5'($urandom_range(0, fill_now - 1));
      else position = 5'($urandom_range(0, fill_now));

      if (!quiet && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 6));
      send_request(mode, value, position);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bale_pkg.sv
rtl/bale_cell.sv
rtl/bale_first_hit.sv
rtl/bounded_array_list_engine_core.sv
test/tb_bounded_array_list_engine_core.sv
